### rtl/arjhdr_pkg.sv
// Package for the ARJ header block checker: parse phases, status codes,
// the parser result struct and the byte-wide CRC-32 update.
// Depends on nothing; used by arjhdr_parser and the top level.
package arjhdr_pkg;

    // Signature bytes of a normal header block.
    localparam logic [7:0] SIG_FIRST = 8'h60;
    localparam logic [7:0] SIG_SECOND = 8'hEA;

    // Reflected CRC-32 polynomial and initial value.
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Reset values of the length limits.
    localparam logic [15:0] MIN_LEN_RESET = 16'd30;
    localparam logic [15:0] MAX_LEN_RESET = 16'd2600;

    // Configuration register indexes.
    localparam logic CFG_MIN_LEN = 1'b0;
    localparam logic CFG_MAX_LEN = 1'b1;

    typedef enum logic [2:0] {
        PH_SIG0   = 3'd0,
        PH_SIG1   = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_LEN_HI = 3'd3,
        PH_BODY   = 3'd4,
        PH_CRC    = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_TERM    = 2'd1,
        ST_CORRUPT = 2'd2
    } status_t;

    // Result of one processed item.
    typedef struct packed {
        logic        emit;
        status_t     status;
        logic [15:0] length;
    } result_t;

    // One byte through the reflected CRC-32, one bit per step.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/arjhdr_parser.sv
// Header block parser: phase state machine, length and CRC registers.
// Processes one byte per enabled cycle. Depends on arjhdr_pkg.
module arjhdr_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            data_byte,
    input  logic                  extended_block,
    input  logic [15:0]           min_len,
    input  logic [15:0]           max_len,
    output arjhdr_pkg::result_t   result
);

    arjhdr_pkg::phase_t phase_reg, phase_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] rx_crc_reg, rx_crc_next;
    logic        ext_reg, ext_next;

    logic [15:0] full_len;
    logic [15:0] count_inc;
    logic [31:0] rx_crc_merged;

    assign full_len  = {data_byte, length_reg[7:0]};
    assign count_inc = count_reg + 16'd1;

    // Place the incoming CRC byte at its little-endian position.
    always_comb
    begin
        rx_crc_merged = rx_crc_reg;
        case (count_reg[1:0])
            2'd0: rx_crc_merged[7:0]   = rx_crc_reg[7:0]   | data_byte;
            2'd1: rx_crc_merged[15:8]  = rx_crc_reg[15:8]  | data_byte;
            2'd2: rx_crc_merged[23:16] = rx_crc_reg[23:16] | data_byte;
            default: rx_crc_merged[31:24] = rx_crc_reg[31:24] | data_byte;
        endcase
    end

    // Next state and result for the byte in hand.
    always_comb
    begin
        phase_next    = phase_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        crc_next      = crc_reg;
        rx_crc_next   = rx_crc_reg;
        ext_next      = ext_reg;
        result.emit   = 1'b0;
        result.status = arjhdr_pkg::ST_GOOD;
        result.length = 16'd0;
        if (step)
        begin
            case (phase_reg)
                arjhdr_pkg::PH_SIG0:
                begin
                    ext_next = extended_block;
                    if (extended_block)
                    begin
                        length_next = {8'd0, data_byte};
                        phase_next  = arjhdr_pkg::PH_LEN_HI;
                    end
                    else if (data_byte != arjhdr_pkg::SIG_FIRST)
                    begin
                        result.emit   = 1'b1;
                        result.status = arjhdr_pkg::ST_CORRUPT;
                        phase_next    = arjhdr_pkg::PH_SIG0;
                    end
                    else
                    begin
                        phase_next = arjhdr_pkg::PH_SIG1;
                    end
                end
                arjhdr_pkg::PH_SIG1:
                begin
                    if (data_byte != arjhdr_pkg::SIG_SECOND)
                    begin
                        result.emit   = 1'b1;
                        result.status = arjhdr_pkg::ST_CORRUPT;
                        phase_next    = arjhdr_pkg::PH_SIG0;
                    end
                    else
                    begin
                        phase_next = arjhdr_pkg::PH_LEN_LO;
                    end
                end
                arjhdr_pkg::PH_LEN_LO:
                begin
                    length_next = {8'd0, data_byte};
                    phase_next  = arjhdr_pkg::PH_LEN_HI;
                end
                arjhdr_pkg::PH_LEN_HI:
                begin
                    length_next = full_len;
                    if (full_len == 16'd0)
                    begin
                        result.emit   = 1'b1;
                        result.status = arjhdr_pkg::ST_TERM;
                        phase_next    = arjhdr_pkg::PH_SIG0;
                    end
                    else if (!ext_reg && (full_len < min_len || full_len > max_len))
                    begin
                        result.emit   = 1'b1;
                        result.status = arjhdr_pkg::ST_CORRUPT;
                        result.length = full_len;
                        phase_next    = arjhdr_pkg::PH_SIG0;
                    end
                    else
                    begin
                        crc_next    = arjhdr_pkg::CRC_INIT;
                        rx_crc_next = 32'd0;
                        count_next  = 16'd0;
                        phase_next  = arjhdr_pkg::PH_BODY;
                    end
                end
                arjhdr_pkg::PH_BODY:
                begin
                    crc_next = arjhdr_pkg::crc_byte(crc_reg, data_byte);
                    if (count_inc == length_reg)
                    begin
                        count_next = 16'd0;
                        phase_next = arjhdr_pkg::PH_CRC;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                arjhdr_pkg::PH_CRC:
                begin
                    rx_crc_next = rx_crc_merged;
                    if (count_reg[1:0] == 2'd3)
                    begin
                        count_next    = 16'd0;
                        result.emit   = 1'b1;
                        result.length = length_reg;
                        if ((crc_reg ^ arjhdr_pkg::CRC_INIT) == rx_crc_merged)
                        begin
                            result.status = arjhdr_pkg::ST_GOOD;
                        end
                        else
                        begin
                            result.status = arjhdr_pkg::ST_CORRUPT;
                        end
                        phase_next    = arjhdr_pkg::PH_SIG0;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                default:
                begin
                    phase_next = arjhdr_pkg::PH_SIG0;
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= arjhdr_pkg::PH_SIG0;
            length_reg <= 16'd0;
            count_reg  <= 16'd0;
            crc_reg    <= arjhdr_pkg::CRC_INIT;
            rx_crc_reg <= 32'd0;
            ext_reg    <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            rx_crc_reg <= rx_crc_next;
            ext_reg    <= ext_next;
        end
    end

endmodule

### rtl/arj_header_block_checker_unit.sv
// Top level of the ARJ header block checker: input register, result
// register, length limit registers. Depends on arjhdr_pkg and arjhdr_parser.
//
// The checker takes one header-stream byte per cycle while in_stall is low
// and gives at most one result per byte: block good, zero-length terminator,
// or corrupt, with the block's length field. A byte passes the input
// register, then the result register, on its way to its result; throughput
// is one item per cycle, set by the byte-wide CRC-32 update in the parser.
// in_stall rises only while a byte waits in the input register behind a
// result that the downstream side has not yet taken. Length limits are
// written through the cfg port (index 0 minimum, index 1 maximum) and
// apply only to normal, signed blocks.
module arj_header_block_checker_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Input items.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        extended_block,
    // Result items.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  block_status,
    output logic [15:0] block_length,
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_ext_reg;
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [15:0] length_reg;
    logic [15:0] min_len_reg;
    logic [15:0] max_len_reg;
    logic        advance;
    logic        step;
    logic        in_take;
    arjhdr_pkg::result_t result;

    // The result register can take a new value when empty or being drained.
    assign advance   = !out_valid_reg || !out_stall;
    assign step      = s1_valid_reg && advance;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= data_byte;
            s1_ext_reg  <= extended_block;
        end
    end

    // Length limit registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= arjhdr_pkg::MIN_LEN_RESET;
            max_len_reg <= arjhdr_pkg::MAX_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                arjhdr_pkg::CFG_MIN_LEN: min_len_reg <= cfg_data;
                arjhdr_pkg::CFG_MAX_LEN: max_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    arjhdr_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .data_byte      (s1_byte_reg),
        .extended_block (s1_ext_reg),
        .min_len        (min_len_reg),
        .max_len        (max_len_reg),
        .result         (result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= result.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.emit)
        begin
            status_reg <= result.status;
            length_reg <= result.length;
        end
    end

    assign out_valid    = out_valid_reg;
    assign block_status = status_reg;
    assign block_length = length_reg;

`ifndef SYNTHESIS
    // A stall toward the source is only raised with an item held inside.
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with an empty input register");

    // The parser reports only for an item that is being processed.
    a_emit_step: assert property (@(posedge clk) disable iff (!rst_n)
        result.emit |-> step)
        else $error("parser result without a processed item");

    // A terminator always carries a zero length.
    a_term_len: assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.emit && result.status == arjhdr_pkg::ST_TERM)
        |=> (out_valid && block_length == 16'd0))
        else $error("terminator result with a nonzero length");
`endif

endmodule
